[src/ptrs_pkg.sv]
package ptrs_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int NUM_TASKS_MAX = 16;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 16;
    localparam int TASK_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_CREATE   = 2'd2,
        OP_DELETE   = 2'd3
    } t_op;

    // Code three is never stored.
    typedef enum logic [1:0] {
        TS_DELETED = 2'd0,
        TS_READY   = 2'd1,
        TS_WAITING = 2'd2
    } t_task_st;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

[src/ptrs_if.sv]
// Request channel: one scheduler operation per transaction.
interface ptrs_in_if
    import ptrs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SLOT_W-1:0]   task_slot;
    logic [PERIOD_W-1:0] task_period;

    modport source (output valid, operation, task_slot, task_period, input ready);
    modport sink   (input valid, operation, task_slot, task_period, output ready);
endinterface

// Response channel: one result per request.
interface ptrs_out_if
    import ptrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              status;
    logic              dispatch_valid;
    logic [TASK_W-1:0] dispatch_task;

    modport source (output valid, status, dispatch_valid, dispatch_task, input ready);
    modport sink   (input valid, status, dispatch_valid, dispatch_task, output ready);
endinterface

[src/periodic_task_ready_scheduler.sv]
// Fixed-priority periodic task scheduler.
// Requests arrive on i_in (valid/ready), one operation per transaction:
// tick, dispatch, create or delete. Every request produces exactly one
// response transaction on o_out carrying status, dispatch_valid and
// dispatch_task.
// Create and delete go from acceptance straight to the push state.
// A dispatch walks the task table one entry per cycle; the first ready
// entry ends the walk.
// A tick runs one shared 16-bit restoring remainder unit, one bit per cycle,
// for each waiting task, stepping through the scan, load, divide and check
// states; other table entries are only scanned, and the response is handed
// over in the push state.
// i_in.ready is high only while the sequencer is idle. The response sits in
// an output register; the next request is accepted while it waits, and the
// sequencer holds its finished result until the register frees up, so a
// stalled receiver simply pauses the block without losing anything.
// Synchronous active-low reset marks all tasks deleted, clears the tick
// counter and empties the output register. The period table is not reset;
// it is read only for tasks that have been created.
module periodic_task_ready_scheduler
    import ptrs_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptrs_in_if.sink      i_in,
    ptrs_out_if.source   o_out
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(PERIOD_W);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TSCAN = 7'b0000010,
        S_TLOAD = 7'b0000100,
        S_TDIV  = 7'b0001000,
        S_TCHK  = 7'b0010000,
        S_DSCAN = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [PERIOD_W-1:0]   r_rem, n_rem;
    logic [PERIOD_W-1:0]   r_quo, n_quo;
    logic [PERIOD_W-1:0]   r_tick, n_tick;
    logic                  r_res_status, n_res_status;
    logic                  r_res_valid, n_res_valid;
    logic [TASK_W-1:0]     r_res_task, n_res_task;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_status, n_out_status;
    logic                  r_out_dvalid, n_out_dvalid;
    logic [TASK_W-1:0]     r_out_task, n_out_task;

    t_task_st              r_status [NUM_TASKS];
    logic [PERIOD_W-1:0]   r_period [NUM_TASKS];
    logic [PERIOD_W-1:0]   r_per_rd;

    logic                  st_we;
    logic [IDX_W-1:0]      st_wa;
    t_task_st              st_wd;
    logic                  per_we;
    logic [IDX_W-1:0]      per_wa;

    logic                  accept;
    logic                  last;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_idx;
    logic [PERIOD_W:0]     rem_sh;
    logic [PERIOD_W:0]     rem_diff;
    logic [TASK_W+IDX_W-1:0] idx_ext;

    assign i_in.ready           = (r_state == S_IDLE);
    assign accept               = i_in.valid && i_in.ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.dispatch_valid = r_out_dvalid;
    assign o_out.dispatch_task  = r_out_task;

    assign last     = (r_idx == IDX_W'(NUM_TASKS - 1));
    assign slot_ok  = ({1'b0, i_in.task_slot} < (SLOT_W + 1)'(NUM_TASKS));
    assign slot_idx = IDX_W'(i_in.task_slot);
    assign idx_ext  = (TASK_W + IDX_W)'(r_idx);

    // One step of the restoring remainder: shift in the next dividend bit,
    // subtract the period when it fits.
    assign rem_sh   = {r_rem, r_quo[PERIOD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_per_rd};

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_tick       = r_tick;
        n_res_status = r_res_status;
        n_res_valid  = r_res_valid;
        n_res_task   = r_res_task;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_dvalid = r_out_dvalid;
        n_out_task   = r_out_task;
        st_we        = 1'b0;
        st_wa        = r_idx;
        st_wd        = TS_DELETED;
        per_we       = 1'b0;
        per_wa       = slot_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = STATUS_OK;
                    n_res_valid  = 1'b0;
                    n_res_task   = '0;
                    n_idx        = '0;
                    case (t_op'(i_in.operation))
                        OP_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_state = S_TSCAN;
                        end
                        OP_DISPATCH: begin
                            n_state = S_DSCAN;
                        end
                        OP_CREATE: begin
                            n_state = S_PUSH;
                            if (!slot_ok || i_in.task_period == '0) begin
                                n_res_status = STATUS_ERR;
                            end else if (r_status[slot_idx] != TS_DELETED) begin
                                n_res_status = STATUS_ERR;
                            end else begin
                                per_we = 1'b1;
                                st_we  = 1'b1;
                                st_wa  = slot_idx;
                                st_wd  = TS_READY;
                            end
                        end
                        OP_DELETE: begin
                            n_state = S_PUSH;
                            if (!slot_ok) begin
                                n_res_status = STATUS_ERR;
                            end else begin
                                st_we = 1'b1;
                                st_wa = slot_idx;
                                st_wd = TS_DELETED;
                            end
                        end
                        default: begin
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_TSCAN: begin
                if (r_status[r_idx] == TS_WAITING) begin
                    n_state = S_TLOAD;
                end else if (last) begin
                    n_state = S_PUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TLOAD: begin
                // r_per_rd now holds the period of the entry under test.
                if (r_per_rd == '0) begin
                    if (last) begin
                        n_state = S_PUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_TSCAN;
                    end
                end else begin
                    n_rem   = '0;
                    n_quo   = r_tick;
                    n_cnt   = '0;
                    n_state = S_TDIV;
                end
            end
            S_TDIV: begin
                n_rem = rem_diff[PERIOD_W] ? rem_sh[PERIOD_W-1:0] : rem_diff[PERIOD_W-1:0];
                n_quo = {r_quo[PERIOD_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PERIOD_W - 1)) begin
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                if (r_rem == '0) begin
                    st_we = 1'b1;
                    st_wd = TS_READY;
                end
                if (last) begin
                    n_state = S_PUSH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TSCAN;
                end
            end
            S_DSCAN: begin
                if (r_status[r_idx] == TS_READY) begin
                    st_we       = 1'b1;
                    st_wd       = TS_WAITING;
                    n_res_valid = 1'b1;
                    n_res_task  = idx_ext[TASK_W-1:0];
                    n_state     = S_PUSH;
                end else if (last) begin
                    n_state = S_PUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_dvalid = r_res_valid;
                    n_out_task   = r_res_task;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_status[i] <= TS_DELETED;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            if (st_we) begin
                r_status[st_wa] <= st_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_res_status <= n_res_status;
        r_res_valid  <= n_res_valid;
        r_res_task   <= n_res_task;
        r_out_status <= n_out_status;
        r_out_dvalid <= n_out_dvalid;
        r_out_task   <= n_out_task;
    end

    // Period table: one write port for create, one registered read port
    // addressed by the scan index.
    always_ff @(posedge i_clk) begin
        if (per_we) begin
            r_period[per_wa] <= i_in.task_period;
        end
        r_per_rd <= r_period[r_idx];
    end

endmodule
